// ===== rtl/tsts_pkg.sv =====
package tsts_pkg;

  localparam int TIME_W        = 32;
  localparam int SLOT_W        = 4;
  localparam int ACT_W         = 3;
  localparam int STATUS_W      = 2;
  localparam int MAX_SLOTS     = 16;
  localparam int NUM_SLOTS_DEF = 16;

  localparam logic [ACT_W-1:0] ACT_ADD      = 3'd0;
  localparam logic [ACT_W-1:0] ACT_ENABLE   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DISABLE  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_SET_NEXT = 3'd3;
  localparam logic [ACT_W-1:0] ACT_RUN      = 3'd4;

  localparam logic [STATUS_W-1:0] ST_ADDED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FIRED = 2'd3;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [TIME_W-1:0] now_ms;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] delay_ms;
    logic [TIME_W-1:0] period_ms;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   result_slot;
    logic                last;
  } result_t;

endpackage

// ===== rtl/tsts_ram.sv =====
module tsts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tsts_alu.sv =====
module tsts_alu
  import tsts_pkg::*;
(
  input  alu_op_t           op,
  input  logic [TIME_W-1:0] a,
  input  logic [TIME_W-1:0] b,
  output logic [TIME_W-1:0] sum,
  output logic              ge
);

  logic            sub;
  logic [TIME_W:0] full;

  // Subtraction reuses the adder with an inverted operand; the carry out
  // is then the unsigned a >= b flag.
  assign sub  = (op == ALU_SUB);
  assign full = {1'b0, a} + {1'b0, b ^ {TIME_W{sub}}} + {{TIME_W{1'b0}}, sub};
  assign sum  = full[TIME_W-1:0];
  assign ge   = sub & full[TIME_W];

endmodule

// ===== rtl/task_slot_timer_scheduler.sv =====
// Channel   | Ports                      | Handshake
// ----------+----------------------------+---------------------------------------
// request   | start, busy, request       | taken when start is high, busy low
// result    | result_valid, result       | one cycle per result, cannot be held
//
// Add, enable, disable, set-next and unknown actions keep busy high for one
// cycle and give their result in the cycle after that.
// Run walks the slots one at a time through the shared adder after S_EXEC: a
// skipped slot passes S_SCAN and S_STEP, one that is enabled adds S_CHECK, and
// one that fires adds S_RELOAD when its period is nonzero. Reset empties the
// table at once; add writes periods; add, set-next and reload write due times.
module task_slot_timer_scheduler
  import tsts_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  request_t request,
  output logic     result_valid,
  output result_t  result
);

  localparam int LIVE  = (NUM_SLOTS < MAX_SLOTS) ? NUM_SLOTS : MAX_SLOTS;
  localparam int IDX_W = (LIVE > 1) ? $clog2(LIVE) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LIVE - 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EXEC   = 6'b000010,
    S_SCAN   = 6'b000100,
    S_CHECK  = 6'b001000,
    S_RELOAD = 6'b010000,
    S_STEP   = 6'b100000
  } state_t;

  state_t            state;
  request_t          req;
  logic [LIVE-1:0]   used;
  logic [LIVE-1:0]   enabled;
  logic [IDX_W-1:0]  idx;

  logic [IDX_W-1:0]  free_idx;
  logic              any_free;
  logic              in_table;
  logic [IDX_W-1:0]  req_idx;

  alu_op_t           alu_op;
  logic [TIME_W-1:0] alu_b;
  logic [TIME_W-1:0] alu_sum;
  logic              alu_ge;

  logic              due_we;
  logic [IDX_W-1:0]  due_waddr;
  logic              per_we;
  logic [TIME_W-1:0] due_rd;
  logic [TIME_W-1:0] per_rd;

  assign busy     = (state != S_IDLE);
  assign any_free = ~&used;
  assign in_table = ({1'b0, req.slot} < (SLOT_W + 1)'(LIVE));
  assign req_idx  = req.slot[IDX_W-1:0];

  always_comb begin
    free_idx = '0;
    for (int i = LIVE - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    alu_op    = ALU_ADD;
    alu_b     = req.delay_ms;
    due_we    = 1'b0;
    due_waddr = idx;
    per_we    = 1'b0;
    case (state)
      S_EXEC: begin
        if (req.action == ACT_ADD && any_free) begin
          due_we    = 1'b1;
          due_waddr = free_idx;
          per_we    = 1'b1;
        end else if (req.action == ACT_SET_NEXT && in_table) begin
          due_we    = 1'b1;
          due_waddr = req_idx;
        end
      end
      S_CHECK: begin
        alu_op = ALU_SUB;
        alu_b  = due_rd;
      end
      S_RELOAD: begin
        alu_b  = per_rd;
        due_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  tsts_alu u_alu (
    .op  (alu_op),
    .a   (req.now_ms),
    .b   (alu_b),
    .sum (alu_sum),
    .ge  (alu_ge)
  );

  tsts_ram #(
    .WIDTH (TIME_W),
    .DEPTH (LIVE)
  ) u_due_ram (
    .clk   (clk),
    .we    (due_we),
    .waddr (due_waddr),
    .wdata (alu_sum),
    .raddr (idx),
    .rdata (due_rd)
  );

  tsts_ram #(
    .WIDTH (TIME_W),
    .DEPTH (LIVE)
  ) u_period_ram (
    .clk   (clk),
    .we    (per_we),
    .waddr (free_idx),
    .wdata (req.period_ms),
    .raddr (idx),
    .rdata (per_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      used         <= '0;
      enabled      <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            req   <= request;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          result_valid <= 1'b1;
          result       <= '{status: ST_DONE, result_slot: '0, last: 1'b1};
          state        <= S_IDLE;
          case (req.action)
            ACT_ADD: begin
              if (any_free) begin
                used[free_idx]    <= 1'b1;
                enabled[free_idx] <= 1'b0;
                result <= '{status: ST_ADDED, result_slot: SLOT_W'(free_idx), last: 1'b1};
              end else begin
                result <= '{status: ST_FULL, result_slot: '0, last: 1'b1};
              end
            end
            ACT_ENABLE: begin
              if (in_table) begin
                enabled[req_idx] <= 1'b1;
              end
            end
            ACT_DISABLE: begin
              if (in_table) begin
                enabled[req_idx] <= 1'b0;
              end
            end
            ACT_RUN: begin
              result_valid <= 1'b0;
              idx          <= '0;
              state        <= S_SCAN;
            end
            default: begin
            end
          endcase
        end
        S_SCAN: begin
          if (used[idx] && enabled[idx]) begin
            state <= S_CHECK;
          end else begin
            state <= S_STEP;
          end
        end
        S_CHECK: begin
          state <= S_STEP;
          if (alu_ge) begin
            result_valid <= 1'b1;
            result <= '{status: ST_FIRED, result_slot: SLOT_W'(idx), last: 1'b0};
            if (per_rd != '0) begin
              state <= S_RELOAD;
            end else begin
              used[idx]    <= 1'b0;
              enabled[idx] <= 1'b0;
            end
          end
        end
        S_RELOAD: begin
          state <= S_STEP;
        end
        S_STEP: begin
          if (idx == LAST_IDX) begin
            result_valid <= 1'b1;
            result       <= '{status: ST_DONE, result_slot: '0, last: 1'b1};
            state        <= S_IDLE;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_SCAN;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/tsts_checker.sv =====
module tsts_checker
  import tsts_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input logic     result_valid,
  input result_t  result
);

  // An accepted request keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy did not rise after an accepted request");

  // Every result belongs to work that was under way in the cycle before.
  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result without a request in progress");

  // A result that is not the last one leaves the block busy.
  a_not_last_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |-> busy)
    else $error("block idle before the final result");

  // The final result frees the block for the next request.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |-> !busy)
    else $error("block still busy at the final result");

  // A fired task is never the final result of a run.
  a_fired_not_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_FIRED |-> !result.last)
    else $error("fired result marked as last");

endmodule

bind task_slot_timer_scheduler tsts_checker u_tsts_checker (.*);
